[rtl/core/rgbnv_pkg.sv]
`timescale 1ns / 1ps
package rgbnv_pkg;

   localparam int COUNT_W    = 12;
   localparam int HALF_W     = 12;
   localparam int STRIDE_W   = 14;
   localparam int SLICE_W    = 13;
   localparam int OFFSET_W   = 26;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int MAX_HALF_HEIGHT = 2048;

   localparam logic [HALF_W-1:0]   HALF_WIDTH_RESET   = 12'd960;
   localparam logic [HALF_W-1:0]   HALF_HEIGHT_RESET  = 12'd540;
   localparam logic [STRIDE_W-1:0] ROW_STRIDE_RESET   = 14'd1920;
   localparam logic [SLICE_W-1:0]  SLICE_HEIGHT_RESET = 13'd1080;

   typedef enum logic [1:0] {
      REG_HALF_WIDTH   = 2'd0,
      REG_HALF_HEIGHT  = 2'd1,
      REG_ROW_STRIDE   = 2'd2,
      REG_SLICE_HEIGHT = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      PLANE_LUMA = 2'd0,
      PLANE_U    = 2'd1,
      PLANE_V    = 2'd2
   } plane_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // red in the low bits, as the line entry is laid out
   typedef struct packed {
      logic [8:0] blue;
      logic [8:0] green;
      logic [8:0] red;
   } pair_sum_type;

   typedef struct packed {
      logic [STRIDE_W-1:0] width_px;
      logic [SLICE_W-1:0]  height_px;
      logic [STRIDE_W-1:0] row_stride;
      logic [OFFSET_W-1:0] uv_base;
   } cfg_type;

   typedef struct packed {
      logic [7:0]          luma;
      logic [7:0]          u_val;
      logic [7:0]          v_val;
      logic [OFFSET_W-1:0] luma_offset;
      logic [OFFSET_W-1:0] uv_offset;
      logic                chroma;
      logic                frame_end;
   } item_type;

   function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      logic [16:0] acc;
      acc = 17'd66 * {9'd0, r} + 17'd129 * {9'd0, g} + 17'd25 * {9'd0, b} + 17'd128;
      return acc[15:8] + 8'd16;
   endfunction

   // bias of 128*256 keeps the sum positive
   function automatic logic [7:0] u_of(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
      logic [16:0] acc;
      acc = 17'd32896 + 17'd112 * {9'd0, b} - 17'd38 * {9'd0, r} - 17'd74 * {9'd0, g};
      return acc[15:8];
   endfunction

   function automatic logic [7:0] v_of(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
      logic [16:0] acc;
      acc = 17'd32896 + 17'd112 * {9'd0, r} - 17'd94 * {9'd0, g} - 17'd18 * {9'd0, b};
      return acc[15:8];
   endfunction

endpackage

[rtl/core/rgbnv_pixel_if.sv]
`timescale 1ns / 1ps
interface rgbnv_pixel_if ();
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

[rtl/core/rgbnv_byte_if.sv]
`timescale 1ns / 1ps
interface rgbnv_byte_if import rgbnv_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] byte_offset;
   logic [7:0]          byte_value;
   logic [1:0]          plane_kind;
   logic                run_last;
   logic                frame_end;

   modport source (output valid, byte_offset, byte_value, plane_kind, run_last, frame_end,
                   input ready);
   modport sink (input valid, byte_offset, byte_value, plane_kind, run_last, frame_end,
                 output ready);
endinterface

[rtl/core/rgbnv_csr.sv]
`timescale 1ns / 1ps
module rgbnv_csr import rgbnv_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   localparam int LINE_DEPTH = MAX_WIDTH / 2;

   logic [HALF_W-1:0]   half_width_ff, half_width_in;
   logic [HALF_W-1:0]   half_height_ff, half_height_in;
   logic [STRIDE_W-1:0] row_stride_ff, row_stride_in;
   logic [SLICE_W-1:0]  slice_height_ff, slice_height_in;
   logic [OFFSET_W-1:0] uv_base_ff, uv_base_in;
   logic [STRIDE_W+SLICE_W-1:0] base_full;
   logic [HALF_W:0]     hw_clamped;
   logic [HALF_W-1:0]   hh_clamped;
   reg_index_type       sel;
   logic                wr;

   assign pready = 1'b1;
   assign sel    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr     = psel && penable && pwrite;

   always_comb begin
      half_width_in   = half_width_ff;
      half_height_in  = half_height_ff;
      row_stride_in   = row_stride_ff;
      slice_height_in = slice_height_ff;
      if (wr) begin
         unique case (sel)
            REG_HALF_WIDTH:   half_width_in   = pwdata[HALF_W-1:0];
            REG_HALF_HEIGHT:  half_height_in  = pwdata[HALF_W-1:0];
            REG_ROW_STRIDE:   row_stride_in   = pwdata[STRIDE_W-1:0];
            REG_SLICE_HEIGHT: slice_height_in = pwdata[SLICE_W-1:0];
            default:          half_width_in   = half_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff   <= HALF_WIDTH_RESET;
         half_height_ff  <= HALF_HEIGHT_RESET;
         row_stride_ff   <= ROW_STRIDE_RESET;
         slice_height_ff <= SLICE_HEIGHT_RESET;
      end else begin
         half_width_ff   <= half_width_in;
         half_height_ff  <= half_height_in;
         row_stride_ff   <= row_stride_in;
         slice_height_ff <= slice_height_in;
      end
   end

   // chroma plane start, registered after the stride and slice height registers
   assign base_full  = row_stride_ff * slice_height_ff;
   assign uv_base_in = base_full[OFFSET_W-1:0];

   always_ff @(posedge clock) begin
      uv_base_ff <= uv_base_in;
   end

   always_comb begin
      if (half_width_ff == '0) begin
         hw_clamped = (HALF_W+1)'(1);
      end else if ({1'b0, half_width_ff} > (HALF_W+1)'(LINE_DEPTH)) begin
         hw_clamped = (HALF_W+1)'(LINE_DEPTH);
      end else begin
         hw_clamped = {1'b0, half_width_ff};
      end
      if (half_height_ff == '0) begin
         hh_clamped = HALF_W'(1);
      end else if (half_height_ff > HALF_W'(MAX_HALF_HEIGHT)) begin
         hh_clamped = HALF_W'(MAX_HALF_HEIGHT);
      end else begin
         hh_clamped = half_height_ff;
      end
   end

   always_comb begin
      cfg.width_px   = {hw_clamped, 1'b0};
      cfg.height_px  = {hh_clamped, 1'b0};
      cfg.row_stride = row_stride_ff;
      cfg.uv_base    = uv_base_ff;
   end

   always_comb begin
      unique case (sel)
         REG_HALF_WIDTH:   prdata = CSR_DATA_W'(half_width_ff);
         REG_HALF_HEIGHT:  prdata = CSR_DATA_W'(half_height_ff);
         REG_ROW_STRIDE:   prdata = CSR_DATA_W'(row_stride_ff);
         REG_SLICE_HEIGHT: prdata = CSR_DATA_W'(slice_height_ff);
         default:          prdata = '0;
      endcase
   end

endmodule

[rtl/core/rgbnv_line_store.sv]
`timescale 1ns / 1ps
module rgbnv_line_store import rgbnv_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic               clock,
   input  logic               advance,
   input  logic               write,
   input  logic [COUNT_W-1:0] column,
   input  pixel_type          pixel,
   input  pixel_type          left,
   output pixel_type          average
);

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   pair_sum_type line_mem [LINE_DEPTH];
   pair_sum_type pair_in, pair_ff, entry_ff;
   logic [COUNT_W:0]  pair_wide;
   logic [LINE_AW-1:0] index;
   logic [9:0] sum_red, sum_green, sum_blue;

   assign pair_wide = {2'b00, column[COUNT_W-1:1]};
   assign index     = pair_wide[LINE_AW-1:0] & LINE_AW'(LINE_DEPTH - 1);

   // horizontal pair sum of this pixel and the one to its left
   always_comb begin
      pair_in.red   = {1'b0, left.red} + {1'b0, pixel.red};
      pair_in.green = {1'b0, left.green} + {1'b0, pixel.green};
      pair_in.blue  = {1'b0, left.blue} + {1'b0, pixel.blue};
   end

   // one access per pixel: the right pixel of a pair on an even row writes, every other pixel reads
   always_ff @(posedge clock) begin
      if (write) begin
         line_mem[index] <= pair_in;
      end
      if (advance) begin
         pair_ff <= pair_in;
         if (!write) begin
            entry_ff <= line_mem[index];
         end
      end
   end

   always_comb begin
      sum_red       = {1'b0, entry_ff.red} + {1'b0, pair_ff.red};
      sum_green     = {1'b0, entry_ff.green} + {1'b0, pair_ff.green};
      sum_blue      = {1'b0, entry_ff.blue} + {1'b0, pair_ff.blue};
      average.red   = sum_red[9:2];
      average.green = sum_green[9:2];
      average.blue  = sum_blue[9:2];
   end

endmodule

[rtl/core/rgbnv_emit.sv]
`timescale 1ns / 1ps
module rgbnv_emit import rgbnv_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  item_type            item,
   output logic                can_load,
   rgbnv_byte_if.source        rsp
);

   item_type  item_ff;
   logic      valid_ff, valid_in;
   plane_type phase_ff, phase_in;
   logic      xfer;
   logic      last;

   assign xfer     = valid_ff && rsp.ready;
   assign last     = (phase_ff == PLANE_V) || (phase_ff == PLANE_LUMA && !item_ff.chroma);
   assign can_load = !valid_ff || (xfer && last);

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = PLANE_LUMA;
      end else if (xfer) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            unique case (phase_ff)
               PLANE_LUMA: phase_in = PLANE_U;
               PLANE_U:    phase_in = PLANE_V;
               PLANE_V:    phase_in = PLANE_V;
               default:    phase_in = PLANE_LUMA;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PLANE_LUMA;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   always_comb begin
      rsp.valid      = valid_ff;
      rsp.plane_kind = phase_ff;
      rsp.run_last   = last;
      rsp.frame_end  = last && item_ff.frame_end;
      unique case (phase_ff)
         PLANE_LUMA: begin
            rsp.byte_offset = item_ff.luma_offset;
            rsp.byte_value  = item_ff.luma;
         end
         PLANE_U: begin
            rsp.byte_offset = item_ff.uv_offset;
            rsp.byte_value  = item_ff.u_val;
         end
         PLANE_V: begin
            rsp.byte_offset = item_ff.uv_offset + OFFSET_W'(1);
            rsp.byte_value  = item_ff.v_val;
         end
         default: begin
            rsp.byte_offset = item_ff.luma_offset;
            rsp.byte_value  = item_ff.luma;
         end
      endcase
   end

   a_load_starts_luma: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff && phase_ff == PLANE_LUMA)
      else $error("loaded item does not start with luma");

   a_u_then_v: assert property (@(posedge clock) disable iff (reset)
      xfer && phase_ff == PLANE_U |=> valid_ff && phase_ff == PLANE_V)
      else $error("U transfer not followed by V");

   a_luma_only: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !item_ff.chroma |-> phase_ff == PLANE_LUMA)
      else $error("chroma phase on a luma-only pixel");

endmodule

[rtl/core/rgba_to_nv12_converter.sv]
`timescale 1ns / 1ps
// RGB pixels in raster order go in on req_pixel, one transfer per pixel, and NV12 bytes
// come out on rsp_byte, one byte per transfer: a luma byte for every pixel, followed by
// the U and V bytes of a 2x2 block at each odd-row, odd-column pixel. A pixel can be
// taken every cycle while the byte port does not stall the pipeline; it runs through a
// pipeline (line store access, luma and address products, chroma and final offsets) and
// a result serializer that sends the luma byte of a pixel, then U and V at a corner.
// The byte port sets the rate: a pixel occupies it for one byte transfer, or three at a
// block corner, 1.5 bytes per pixel over a frame. The line store is a single-port memory
// of MAX_WIDTH/2 entries, one access per pixel (a write for the right pixel of a pair on
// an even row, a read for every other pixel); it needs no clearing after reset. Frame
// sizes are programmed as half width and half height over the APB port and should be
// changed only between frames.
module rgba_to_nv12_converter import rgbnv_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   rgbnv_pixel_if.sink           req_pixel,
   rgbnv_byte_if.source          rsp_byte,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;

   // raster position and the previous pixel
   logic [COUNT_W-1:0] col_ff, col_in;
   logic [COUNT_W-1:0] row_ff, row_in;
   pixel_type          left_ff, left_in;
   pixel_type          pixel;
   logic [STRIDE_W-1:0] col_p1;
   logic [SLICE_W-1:0]  row_p1;
   logic row_end, frame_end, chroma, line_write;
   logic accept, advance, emit_ready;

   // stage b: line store data on its way
   logic               b_valid_ff, b_valid_in;
   pixel_type          b_pixel_ff;
   logic [COUNT_W-1:0] b_col_ff, b_row_ff;
   logic               b_chroma_ff, b_fend_ff;
   pixel_type          average;

   // stage c: luma, averages and address products
   logic                c_valid_ff, c_valid_in;
   logic [7:0]          c_luma_ff, c_luma_in;
   pixel_type           c_avg_ff;
   logic [OFFSET_W-1:0] c_row_prod_ff, c_row_prod_in;
   logic [OFFSET_W-2:0] c_half_prod_ff, c_half_prod_in;
   logic [COUNT_W-1:0]  c_col_ff;
   logic                c_chroma_ff, c_fend_ff;
   item_type            item;

   rgbnv_csr #(.MAX_WIDTH(MAX_WIDTH)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // whole pipeline moves together; a bubble in stage c never blocks
   assign advance         = !c_valid_ff || emit_ready;
   assign req_pixel.ready = advance;
   assign accept          = req_pixel.valid && advance;

   assign pixel.red   = req_pixel.red;
   assign pixel.green = req_pixel.green;
   assign pixel.blue  = req_pixel.blue;

   assign col_p1     = {2'b00, col_ff} + STRIDE_W'(1);
   assign row_p1     = {1'b0, row_ff} + SLICE_W'(1);
   assign row_end    = col_p1 >= cfg.width_px;
   assign frame_end  = row_end && (row_p1 >= cfg.height_px);
   assign chroma     = col_ff[0] && row_ff[0];
   // right pixel of a pair on an even row stores the pair sum
   assign line_write = accept && col_ff[0] && !row_ff[0];

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      if (accept) begin
         left_in = pixel;
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_p1[COUNT_W-1:0];
         end else begin
            col_in = col_p1[COUNT_W-1:0];
         end
      end
   end

   always_comb begin
      b_valid_in = advance ? accept : b_valid_ff;
      c_valid_in = advance ? b_valid_ff : c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         left_ff    <= '0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         left_ff    <= left_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   rgbnv_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
      .clock   (clock),
      .advance (advance),
      .write   (line_write),
      .column  (col_ff),
      .pixel   (pixel),
      .left    (left_ff),
      .average (average)
   );

   // stage b payload
   always_ff @(posedge clock) begin
      if (advance) begin
         b_pixel_ff  <= pixel;
         b_col_ff    <= col_ff;
         b_row_ff    <= row_ff;
         b_chroma_ff <= chroma;
         b_fend_ff   <= frame_end;
      end
   end

   // luma and the two row products, each product registered
   always_comb begin
      c_luma_in      = luma_of(b_pixel_ff.red, b_pixel_ff.green, b_pixel_ff.blue);
      c_row_prod_in  = b_row_ff * cfg.row_stride;
      c_half_prod_in = b_row_ff[COUNT_W-1:1] * cfg.row_stride;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_luma_ff      <= c_luma_in;
         c_avg_ff       <= average;
         c_row_prod_ff  <= c_row_prod_in;
         c_half_prod_ff <= c_half_prod_in;
         c_col_ff       <= b_col_ff;
         c_chroma_ff    <= b_chroma_ff;
         c_fend_ff      <= b_fend_ff;
      end
   end

   // chroma values and final offsets, all wrapping at the offset width
   always_comb begin
      item.luma        = c_luma_ff;
      item.u_val       = u_of(c_avg_ff.red, c_avg_ff.green, c_avg_ff.blue);
      item.v_val       = v_of(c_avg_ff.red, c_avg_ff.green, c_avg_ff.blue);
      item.luma_offset = c_row_prod_ff + {14'd0, c_col_ff};
      item.uv_offset   = cfg.uv_base + {1'b0, c_half_prod_ff}
                         + {14'd0, c_col_ff[COUNT_W-1:1], 1'b0};
      item.chroma      = c_chroma_ff;
      item.frame_end   = c_fend_ff;
   end

   rgbnv_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (c_valid_ff && advance),
      .item     (item),
      .can_load (emit_ready),
      .rsp      (rsp_byte)
   );

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && frame_end |=> col_ff == '0 && row_ff == '0)
      else $error("raster position not cleared at frame end");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && row_end && !frame_end |=> col_ff == '0 && row_ff == $past(row_ff) + 12'd1)
      else $error("row end did not step to the next row");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff && !advance |=> c_valid_ff && $stable(c_luma_ff) && $stable(c_col_ff))
      else $error("stage c changed while stalled");

endmodule

[bench/tb_rgba_to_nv12_converter.sv]
`timescale 1ns / 1ps
module tb_rgba_to_nv12_converter;
   import rgbnv_pkg::*;

   localparam int MAX_WIDTH       = 4096;
   localparam int LINE_ENTRIES    = MAX_WIDTH / 2;
   localparam int RESET_CYCLES    = 9;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int DRAIN_CYCLES    = 20;
   localparam int RANDOM_PIXELS   = 250;
   localparam int REPORT_LIMIT    = 10;
   localparam int LIMIT_NS        = 1_000_000;

   typedef enum logic [0:0] {
      STEP_PIXEL = 1'b0,
      STEP_CSR   = 1'b1
   } step_kind_type;

   // one byte of the nv12 buffer as it leaves the block
   typedef struct packed {
      logic [OFFSET_W-1:0] byte_off;
      logic [7:0]          byte_val;
      plane_type           plane;
      logic                last;
      logic                fend;
   } nv12_byte_type;

   // one row of stimulus: a pixel, or a register write done with the block idle
   typedef struct packed {
      step_kind_type kind;
      reg_index_type reg_idx;
      logic [31:0]   reg_value;
      pixel_type     px;
      logic          typed;   // luma byte below is the expected result, taken as is
      nv12_byte_type luma;
   } stim_step_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   rgbnv_pixel_if pixel_bus ();
   rgbnv_byte_if  byte_bus ();

   rgba_to_nv12_converter #(
      .MAX_WIDTH(MAX_WIDTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_pixel(pixel_bus),
      .rsp_byte(byte_bus),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // ---------------------------------------------------------------------------
   // converter state mirrored by the bench
   // ---------------------------------------------------------------------------
   int unsigned  cfg_half_width   = HALF_WIDTH_RESET;
   int unsigned  cfg_half_height  = HALF_HEIGHT_RESET;
   int unsigned  cfg_row_stride   = ROW_STRIDE_RESET;
   int unsigned  cfg_slice_height = SLICE_HEIGHT_RESET;
   int unsigned  col_count        = 0;
   int unsigned  row_count        = 0;
   pixel_type    left_pix         = '0;
   pair_sum_type line_sums [LINE_ENTRIES];

   // bytes predicted for accepted pixels, oldest first
   nv12_byte_type expected_bytes[$];
   int            mismatch_count = 0;

   // idling knobs, changed per phase
   bit send_gaps      = 1'b1;
   bit rx_stalls      = 1'b1;
   bit hold_off_armed = 1'b0;

   // ---------------------------------------------------------------------------
   // clock and watchdog
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // predictor: bt.601 luma for every pixel, 2x2 averaged chroma at block corners
   // ---------------------------------------------------------------------------
   task automatic nv12_predict(input pixel_type px);
      int unsigned hw, hh, col, row, lin, uv_full, idx;
      int unsigned sr, sg, sb, y_val;
      int          ar, ag, ab, u_val, v_val;
      logic        row_end, frm_end, corner;
      logic [OFFSET_W-1:0] y_off, uv_off, v_off;
      pair_sum_type sums;

      // sizes are clamped, never rejected
      hw = cfg_half_width;
      hh = cfg_half_height;
      if (hw < 1) hw = 1;
      if (hw > LINE_ENTRIES) hw = LINE_ENTRIES;
      if (hh < 1) hh = 1;
      if (hh > MAX_HALF_HEIGHT) hh = MAX_HALF_HEIGHT;

      col = col_count;
      row = row_count;
      // ">=" so that a width shrunk below the current column still ends the row
      row_end = (col + 1) >= 2 * hw;
      frm_end = row_end && ((row + 1) >= 2 * hh);
      corner  = (col % 2 == 1) && (row % 2 == 1);
      idx     = (col / 2) % LINE_ENTRIES;

      y_val = ((66 * px.red + 129 * px.green + 25 * px.blue + 128) >> 8) + 16;
      lin   = row * cfg_row_stride + col;
      y_off = lin[OFFSET_W-1:0];
      expected_bytes.push_back('{y_off, y_val[7:0], PLANE_LUMA, !corner,
                                 corner ? 1'b0 : frm_end});

      if (corner) begin
         // stored even-row pair plus the current pair, then floor average
         sums = line_sums[idx];
         sr = sums.red + left_pix.red + px.red;
         sg = sums.green + left_pix.green + px.green;
         sb = sums.blue + left_pix.blue + px.blue;
         ar = sr >> 2;
         ag = sg >> 2;
         ab = sb >> 2;
         // 128*256 bias keeps the sums positive before the shift
         u_val = (-38 * ar - 74 * ag + 112 * ab + 128 + 32768) >>> 8;
         v_val = (112 * ar - 94 * ag - 18 * ab + 128 + 32768) >>> 8;
         uv_full = cfg_row_stride * cfg_slice_height + (row / 2) * cfg_row_stride
                   + (col / 2) * 2;
         uv_off = uv_full[OFFSET_W-1:0];
         v_off  = uv_off + 1'b1;
         expected_bytes.push_back('{uv_off, u_val[7:0], PLANE_U, 1'b0, 1'b0});
         expected_bytes.push_back('{v_off, v_val[7:0], PLANE_V, 1'b1, frm_end});
      end else if (col % 2 == 1) begin
         sr = left_pix.red + px.red;
         sg = left_pix.green + px.green;
         sb = left_pix.blue + px.blue;
         line_sums[idx].red   = sr[8:0];
         line_sums[idx].green = sg[8:0];
         line_sums[idx].blue  = sb[8:0];
      end

      left_pix = px;
      if (row_end) begin
         col_count = 0;
         row_count = frm_end ? 0 : (row + 1) % 4096;
      end else begin
         col_count = (col + 1) % 4096;
      end
   endtask

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic stim_step_type pix(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
      stim_step_type st;
      st = '0;
      st.kind = STEP_PIXEL;
      st.px   = '{red: r, green: g, blue: b};
      return st;
   endfunction

   // pixel whose single luma byte is easy to work out by hand
   function automatic stim_step_type pix_y(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input int unsigned off,
                                           input logic [7:0] y, input logic fend);
      stim_step_type st;
      st = pix(r, g, b);
      st.typed = 1'b1;
      st.luma  = '{off[OFFSET_W-1:0], y, PLANE_LUMA, 1'b1, fend};
      return st;
   endfunction

   function automatic stim_step_type csr(input reg_index_type idx, input int unsigned value);
      stim_step_type st;
      st = '0;
      st.kind      = STEP_CSR;
      st.reg_idx   = idx;
      st.reg_value = value;
      return st;
   endfunction

   // mostly short, now and then long
   function automatic int pick_idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 2);
      if (roll < 95) return $urandom_range(3, 6);
      return $urandom_range(20, 40);
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_pixel(input stim_step_type st);
      int gap;
      gap = (send_gaps && $urandom_range(0, 99) < 30) ? pick_idle_len() : 0;
      if (gap > 0) begin
         pixel_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pixel_bus.valid <= 1'b1;
      pixel_bus.red   <= st.px.red;
      pixel_bus.green <= st.px.green;
      pixel_bus.blue  <= st.px.blue;
      @(posedge clock);
      while (!pixel_bus.ready) @(posedge clock);
      nv12_predict(st.px);
      // a typed row has exactly one luma byte: swap in the hand-made value
      if (st.typed) begin
         void'(expected_bytes.pop_back());
         expected_bytes.push_back(st.luma);
      end
      @(negedge clock);
   endtask

   // every pixel leaves at least one byte, so an empty queue means the block is idle
   task automatic wait_drained();
      while (expected_bytes.size() != 0) @(negedge clock);
   endtask

   // setup then access; psel stays up so writes can run back to back
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_HALF_WIDTH:   cfg_half_width   = value[HALF_W-1:0];
         REG_HALF_HEIGHT:  cfg_half_height  = value[HALF_W-1:0];
         REG_ROW_STRIDE:   cfg_row_stride   = value[STRIDE_W-1:0];
         REG_SLICE_HEIGHT: cfg_slice_height = value[SLICE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic void report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
   endfunction

   // ---------------------------------------------------------------------------
   // result side: ready with random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin : byte_ready_driver
      byte_bus.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_off_armed) begin
            // long stretch with no transfer: the pipeline fills and stalls req_pixel
            byte_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_armed = 1'b0;
         end else if (rx_stalls && $urandom_range(0, 99) < 25) begin
            byte_bus.ready <= 1'b0;
            repeat (pick_idle_len()) @(negedge clock);
         end else begin
            byte_bus.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // every transfer on rsp_byte is matched against the oldest predicted byte
   always @(posedge clock) begin : byte_checker
      nv12_byte_type want;
      if (!reset && byte_bus.valid === 1'b1 && byte_bus.ready === 1'b1) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf(
               "unexpected byte: off %0d val %0d plane %0d last %0b fend %0b",
               byte_bus.byte_offset, byte_bus.byte_value,
               byte_bus.plane_kind, byte_bus.run_last,
               byte_bus.frame_end));
         end else begin
            want = expected_bytes.pop_front();
            if (byte_bus.byte_offset !== want.byte_off ||
                byte_bus.byte_value !== want.byte_val ||
                byte_bus.plane_kind !== want.plane ||
                byte_bus.run_last !== want.last ||
                byte_bus.frame_end !== want.fend) begin
               report_mismatch({
                  $sformatf("exp off %0d val %0d plane %0d last %0b fend %0b",
                            want.byte_off, want.byte_val, want.plane, want.last,
                            want.fend),
                  $sformatf(", got off %0d val %0d plane %0d last %0b fend %0b",
                            byte_bus.byte_offset, byte_bus.byte_value,
                            byte_bus.plane_kind, byte_bus.run_last,
                            byte_bus.frame_end)});
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin : pixel_source
      stim_step_type directed_steps[$];
      logic [7:0] chan [3];
      bit csr_open;
      int phase_idx, random_pixels, pixel_total, frames;
      int hw, hh, stride, slice;

      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      pixel_bus.valid = 1'b0;
      pixel_bus.red   = '0;
      pixel_bus.green = '0;
      pixel_bus.blue  = '0;
      csr_open        = 1'b0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      directed_steps = '{
         // reset sizes: 1920 wide, first row luma only at the column offset
         pix_y(8'd0,   8'd0,   8'd0,   0, 8'd16,  1'b0),
         pix_y(8'd255, 8'd255, 8'd255, 1, 8'd235, 1'b0),
         pix_y(8'd255, 8'd0,   8'd0,   2, 8'd82,  1'b0),
         pix_y(8'd0,   8'd255, 8'd0,   3, 8'd144, 1'b0),
         // shrink mid-row: column 4 is past the new width, so the row wraps
         csr(REG_HALF_WIDTH, 2),
         csr(REG_HALF_HEIGHT, 1),
         pix_y(8'd0,   8'd0,   8'd255, 4, 8'd41,  1'b0),
         // odd row averages against the pairs just stored, frame ends on the v byte
         pix(8'd255, 8'd255, 8'd255),
         pix(8'd255, 8'd255, 8'd255),
         pix(8'd0,   8'd0,   8'd0),
         pix(8'd0,   8'd0,   8'd0),
         // zero sizes clamp to a 2x2 frame, zero stride and plane size stay as given
         csr(REG_ROW_STRIDE, 0),
         csr(REG_SLICE_HEIGHT, 0),
         csr(REG_HALF_WIDTH, 0),
         csr(REG_HALF_HEIGHT, 0),
         pix(8'd0, 8'd0, 8'd255),
         pix(8'd0, 8'd0, 8'd255),
         pix(8'd0, 8'd0, 8'd255),
         pix(8'd0, 8'd0, 8'd255),
         // all-ones register values: sizes clamp, chroma base wraps past 2^26
         csr(REG_ROW_STRIDE, 16383),
         csr(REG_SLICE_HEIGHT, 8191),
         csr(REG_HALF_WIDTH, 4095),
         csr(REG_HALF_HEIGHT, 4095),
         pix(8'd255, 8'd0,   8'd255),
         pix(8'd0,   8'd255, 8'd0),
         pix(8'd255, 8'd255, 8'd0),
         pix(8'd0,   8'd0,   8'd255),
         pix(8'd1,   8'd2,   8'd3),
         pix(8'd254, 8'd253, 8'd252),
         csr(REG_HALF_WIDTH, 2),
         csr(REG_HALF_HEIGHT, 1),
         pix_y(8'd0, 8'd0, 8'd0, 6, 8'd16, 1'b0),
         pix(8'd255, 8'd0,   8'd0),
         pix(8'd0,   8'd255, 8'd255),
         pix(8'd128, 8'd127, 8'd1),
         pix(8'd3,   8'd200, 8'd77)
      };

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR) begin
            if (!csr_open) begin
               pixel_bus.valid <= 1'b0;
               wait_drained();
               csr_open = 1'b1;
            end
            csr_write(directed_steps[i].reg_idx, directed_steps[i].reg_value);
         end else begin
            if (csr_open) begin
               psel     <= 1'b0;
               penable  <= 1'b0;
               pwrite   <= 1'b0;
               csr_open = 1'b0;
            end
            send_pixel(directed_steps[i]);
         end
      end
      pixel_bus.valid <= 1'b0;

      // random phases: each starts with the counters at zero and sends whole frames,
      // so every odd row only reads line entries written on the row above
      phase_idx     = 0;
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         if (phase_idx == 0) begin
            // six rows at the widest stride: chroma offsets wrap modulo 2^26
            hw     = 1;
            hh     = 3;
            stride = 16383;
            slice  = 8191;
         end else if (phase_idx == 1) begin
            // back pressure phase, enough pixels to fill the pipeline
            hw     = 8;
            hh     = 2;
            stride = $urandom_range(16, 8192);
            slice  = $urandom_range(2, 4096);
         end else begin
            case ($urandom_range(0, 9))
               0:       hw = 0;
               1, 2:    hw = $urandom_range(5, 24);
               default: hw = $urandom_range(1, 4);
            endcase
            hh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            case ($urandom_range(0, 7))
               0:       stride = 0;
               1:       stride = 16383;
               2:       stride = 2 * ((hw < 1) ? 1 : hw);
               default: stride = $urandom_range(2, 8192);
            endcase
            case ($urandom_range(0, 7))
               0:       slice = 0;
               1:       slice = 8191;
               default: slice = $urandom_range(2, 4096);
            endcase
         end
         frames      = $urandom_range(1, 2);
         pixel_total = frames * 4 * ((hw < 1) ? 1 : hw) * ((hh < 1) ? 1 : hh);
         // near the end of the pixel budget a late phase falls back to one 2x2 frame
         if (phase_idx > 1 && pixel_total > RANDOM_PIXELS - random_pixels + 8) begin
            hw          = 1;
            hh          = 1;
            frames      = 1;
            pixel_total = 4;
         end

         wait_drained();
         csr_write(REG_HALF_WIDTH, hw);
         csr_write(REG_HALF_HEIGHT, hh);
         csr_write(REG_ROW_STRIDE, stride);
         csr_write(REG_SLICE_HEIGHT, slice);
         psel    <= 1'b0;
         penable <= 1'b0;
         pwrite  <= 1'b0;

         // some phases run with no idling at all on one side or both
         send_gaps = ($urandom_range(0, 3) != 0);
         rx_stalls = ($urandom_range(0, 3) != 0);
         if (phase_idx == 1) begin
            send_gaps      = 1'b0;
            hold_off_armed = 1'b1;
         end

         repeat (pixel_total) begin
            for (int c = 0; c < 3; c++) begin
               if ($urandom_range(0, 9) == 0) chan[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               else chan[c] = 8'($urandom_range(0, 255));
            end
            send_pixel(pix(chan[0], chan[1], chan[2]));
            random_pixels++;
         end
         pixel_bus.valid <= 1'b0;
         phase_idx++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
